[hw/rtl/pic_pkg.sv]
`timescale 1ns / 1ps
package pic_pkg;

  localparam int POSITION_BITS = 16;
  localparam int SEQ_LEN_BITS  = 16;
  localparam int LEN_BITS      = (POSITION_BITS > SEQ_LEN_BITS) ? POSITION_BITS : SEQ_LEN_BITS;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SEQ_LEN = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_I2C_EN  = 1'd1;

  localparam logic [3:0] OP_BEGIN   = 4'd0;
  localparam logic [3:0] OP_END     = 4'd1;
  localparam logic [3:0] OP_CMD     = 4'd2;
  localparam logic [3:0] OP_C8D8    = 4'd3;
  localparam logic [3:0] OP_C8D16   = 4'd4;
  localparam logic [3:0] OP_BYTES   = 4'd5;
  localparam logic [3:0] OP_DELAY   = 4'd6;
  localparam logic [3:0] OP_I2C_REG = 4'd7;
  localparam logic [3:0] OP_I2C_SEQ = 4'd8;
  localparam logic [3:0] OP_REPEAT  = 4'd9;

  localparam logic [3:0] NO_OP = 4'd0;

  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_BEGIN    = 4'd1;
  localparam logic [3:0] ACT_END      = 4'd2;
  localparam logic [3:0] ACT_CMD      = 4'd3;
  localparam logic [3:0] ACT_DATA     = 4'd4;
  localparam logic [3:0] ACT_DELAY    = 4'd5;
  localparam logic [3:0] ACT_I2C_REG  = 4'd6;
  localparam logic [3:0] ACT_SEQ_HEAD = 4'd7;
  localparam logic [3:0] ACT_SEQ_DATA = 4'd8;
  localparam logic [3:0] ACT_REPEAT   = 4'd9;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos;
    logic [3:0]               cur_op;
    logic [7:0]               op_idx;
    logic [7:0]               data_rem;
    logic [7:0]               held_reg;
    logic [7:0]               held_cnt;
    logic                     failed;
  } pic_state_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] repeat_count;
    logic [1:0] status;
  } pic_result_t;

endpackage

[hw/rtl/pic_decode.sv]
`timescale 1ns / 1ps
module pic_decode
  import pic_pkg::*;
(
  input  pic_state_t              st,
  input  logic [7:0]              op_byte,
  input  logic [SEQ_LEN_BITS-1:0] seq_len,
  input  logic                    i2c_en,
  output pic_state_t              st_nxt,
  output pic_result_t             res,
  output logic                    emit
);

  logic [LEN_BITS-1:0]      len_ext;
  logic [LEN_BITS-1:0]      pos_max_ext;
  logic [POSITION_BITS-1:0] len_p;
  logic [POSITION_BITS-1:0] rem;
  logic [LEN_BITS-1:0]      rem_ext;
  logic [LEN_BITS-1:0]      b_ext;
  logic [3:0]               op;
  logic                     drop;
  logic                     err;
  logic                     fin;
  logic                     have;

  always_comb begin
    len_ext     = LEN_BITS'(seq_len);
    pos_max_ext = LEN_BITS'({POSITION_BITS{1'b1}});
    len_p       = (len_ext > pos_max_ext) ? POSITION_BITS'(pos_max_ext)
                                          : POSITION_BITS'(len_ext);
    drop    = st.failed || (st.pos >= len_p);
    rem     = len_p - st.pos - POSITION_BITS'(1);
    rem_ext = LEN_BITS'(rem);
    b_ext   = LEN_BITS'(op_byte);
    op      = st.cur_op - 4'd1;
    st_nxt  = st;
    res     = '{ACT_NONE, 8'd0, 8'd0, 8'd1, ST_BUSY};
    err     = 1'b0;
    fin     = 1'b0;
    have    = 1'b0;
    emit    = 1'b0;
    if (!drop) begin
      if (st.cur_op == NO_OP) begin
        if (op_byte[7:4] != 4'd0) begin
          err = 1'b1;
        end else begin
          case (op_byte[3:0])
            OP_BEGIN: begin
              res.action = ACT_BEGIN;
              have = 1'b1;
            end
            OP_END: begin
              res.action = ACT_END;
              have = 1'b1;
            end
            OP_CMD, OP_DELAY, OP_BYTES: err = (rem_ext < LEN_BITS'(1));
            OP_C8D8: err = (rem_ext < LEN_BITS'(2));
            OP_C8D16: err = (rem_ext < LEN_BITS'(3));
            OP_I2C_REG, OP_I2C_SEQ: err = (rem_ext < LEN_BITS'(2)) || !i2c_en;
            OP_REPEAT: err = (rem_ext < LEN_BITS'(4)) || !i2c_en;
            default: err = 1'b1;
          endcase
        end
        if (!err && op_byte[7:4] == 4'd0 && op_byte[3:0] >= OP_CMD) begin
          st_nxt.cur_op   = op_byte[3:0] + 4'd1;
          st_nxt.op_idx   = 8'd0;
          st_nxt.data_rem = 8'd0;
        end
      end else begin
        if (st.op_idx != 8'hFF) begin
          st_nxt.op_idx = st.op_idx + 8'd1;
        end
        case (op)
          OP_CMD: begin
            res.action = ACT_CMD;
            res.first_byte = op_byte;
            have = 1'b1;
            fin = 1'b1;
          end
          OP_C8D8: begin
            res.action = (st.op_idx == 8'd0) ? ACT_CMD : ACT_DATA;
            res.first_byte = op_byte;
            have = 1'b1;
            fin = (st.op_idx != 8'd0);
          end
          OP_C8D16: begin
            res.action = (st.op_idx == 8'd0) ? ACT_CMD : ACT_DATA;
            res.first_byte = op_byte;
            have = 1'b1;
            fin = (st.op_idx >= 8'd2);
          end
          OP_BYTES: begin
            if (st.op_idx == 8'd0) begin
              if (b_ext > rem_ext) begin
                err = 1'b1;
              end else if (op_byte == 8'd0) begin
                fin = 1'b1;
              end else begin
                st_nxt.data_rem = op_byte;
              end
            end else begin
              res.action = ACT_DATA;
              res.first_byte = op_byte;
              have = 1'b1;
              st_nxt.data_rem = st.data_rem - 8'd1;
              fin = (st.data_rem == 8'd1);
            end
          end
          OP_DELAY: begin
            res.action = ACT_DELAY;
            res.first_byte = op_byte;
            have = 1'b1;
            fin = 1'b1;
          end
          OP_I2C_REG: begin
            if (st.op_idx == 8'd0) begin
              st_nxt.held_reg = op_byte;
            end else begin
              res.action = ACT_I2C_REG;
              res.first_byte = st.held_reg;
              res.second_byte = op_byte;
              have = 1'b1;
              fin = 1'b1;
            end
          end
          OP_I2C_SEQ: begin
            if (st.op_idx == 8'd0) begin
              st_nxt.held_reg = op_byte;
            end else if (st.op_idx == 8'd1) begin
              if (b_ext > rem_ext) begin
                err = 1'b1;
              end else begin
                res.action = ACT_SEQ_HEAD;
                res.first_byte = st.held_reg;
                res.second_byte = op_byte;
                have = 1'b1;
                st_nxt.data_rem = op_byte;
                fin = (op_byte == 8'd0);
              end
            end else begin
              res.action = ACT_SEQ_DATA;
              res.first_byte = op_byte;
              have = 1'b1;
              st_nxt.data_rem = st.data_rem - 8'd1;
              fin = (st.data_rem == 8'd1);
            end
          end
          OP_REPEAT: begin
            if (st.op_idx == 8'd0) begin
              st_nxt.held_cnt = op_byte;
            end else if (st.op_idx == 8'd1) begin
              err = (op_byte != {4'd0, OP_I2C_REG});
            end else if (st.op_idx == 8'd2) begin
              st_nxt.held_reg = op_byte;
            end else begin
              res.action = ACT_REPEAT;
              res.first_byte = st.held_reg;
              res.second_byte = op_byte;
              res.repeat_count = st.held_cnt;
              have = 1'b1;
              fin = 1'b1;
            end
          end
          default: err = 1'b1;
        endcase
        if (fin || err) begin
          st_nxt.cur_op = NO_OP;
        end
      end
      st_nxt.pos = st.pos + POSITION_BITS'(1);
      if (err) begin
        res = '{ACT_NONE, 8'd0, 8'd0, 8'd1, ST_ERROR};
        st_nxt.failed = 1'b1;
        st_nxt.cur_op = NO_OP;
        emit = 1'b1;
      end else if (st_nxt.pos >= len_p) begin
        if (st_nxt.cur_op != NO_OP) begin
          res.status = ST_ERROR;
          st_nxt.failed = 1'b1;
          st_nxt.cur_op = NO_OP;
        end else begin
          res.status = ST_DONE;
        end
        emit = 1'b1;
      end else begin
        emit = have;
      end
    end
  end

endmodule

[hw/rtl/panel_init_command_interpreter.sv]
`timescale 1ns / 1ps
// Panel init command interpreter.
// Input channel: in_valid/in_ready with in_op_byte, one byte of the init
// sequence per transfer. Output channel: out_valid/out_ready with the bus
// action (out_action, out_first_byte, out_second_byte, out_repeat_count)
// and out_status (in progress, done, error).
// Config channel: cfg_valid/cfg_ready, always ready; index 0 sets the
// sequence length, index 1 enables the I2C opcodes. Write only while idle.
// A byte accepted into the input register is decoded, and its result, if any,
// is loaded into the output register as the byte leaves the input register.
// One byte per cycle is taken sustained while out_ready stays high: an input
// register feeds the decoder, whose state and result registers load together.
// Bytes that only start or feed an operation produce no transfer; after
// the last byte of the sequence or an error, further bytes are dropped.
// Reset clears all decoder state, sets the length to 1 and disables I2C.
// When the receiver stalls, the result holds in the output register; the
// input register still fills, then in_ready drops until out_ready returns.
module panel_init_command_interpreter
  import pic_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              in_op_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [3:0]              out_action,
  output logic [7:0]              out_first_byte,
  output logic [7:0]              out_second_byte,
  output logic [7:0]              out_repeat_count,
  output logic [1:0]              out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [SEQ_LEN_BITS-1:0] cfg_data
);

  logic [SEQ_LEN_BITS-1:0] seq_len_r;
  logic                    i2c_en_r;
  logic                    in_valid_r;
  logic [7:0]              in_byte_r;
  pic_state_t              state_r;
  pic_state_t              state_nxt;
  pic_result_t             res_nxt;
  pic_result_t             out_r;
  logic                    out_valid_r;
  logic                    emit;
  logic                    fire;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;

  pic_decode u_decode (
    .st      (state_r),
    .op_byte (in_byte_r),
    .seq_len (seq_len_r),
    .i2c_en  (i2c_en_r),
    .st_nxt  (state_nxt),
    .res     (res_nxt),
    .emit    (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= SEQ_LEN_BITS'(1);
      i2c_en_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SEQ_LEN: seq_len_r <= cfg_data;
        CFG_I2C_EN:  i2c_en_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
      if (fire && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_op_byte;
    end
    if (fire && emit) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_r.action;
  assign out_first_byte   = out_r.first_byte;
  assign out_second_byte  = out_r.second_byte;
  assign out_repeat_count = out_r.repeat_count;
  assign out_status       = out_r.status;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import pic_pkg::*;

  typedef enum int {
    END_UNKNOWN_OP,
    END_SHORT_OPCODE,
    END_SHORT_COUNT,
    END_I2C_OFF,
    END_NESTED_OP,
    END_UNFINISHED
  } abort_kind_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [7:0]              in_op_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic [3:0]              out_action;
  logic [7:0]              out_first_byte;
  logic [7:0]              out_second_byte;
  logic [7:0]              out_repeat_count;
  logic [1:0]              out_status;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [SEQ_LEN_BITS-1:0] cfg_data;

  panel_init_command_interpreter u_top (.*);

  int          seq_len = 1;
  bit          i2c_on = 1'b0;
  int          seq_pos = 0;
  bit          seq_aborted = 1'b0;
  logic [3:0]  pending_op = NO_OP;
  logic [7:0]  operand_cnt = 8'd0;
  logic [7:0]  bytes_left = 8'd0;
  logic [7:0]  reg_hold = 8'd0;
  logic [7:0]  count_hold = 8'd0;

  pic_result_t expected_actions[$];
  logic [7:0]  stream_bytes[$];

  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int          hold_request = 0;
  int          mismatch_count = 0;
  int          actions_checked = 0;
  int          bytes_decoded = 0;
  int          bytes_dropped = 0;
  int          groups_run = 0;
  abort_kind_t finale = END_UNKNOWN_OP;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic int idle_gap(input bit enabled);
    return enabled ? int'($urandom_range(0, 19)) : 0;
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] rand_count();
    return ($urandom_range(0, 19) == 0) ? 8'($urandom_range(7, 255)) : 8'($urandom_range(0, 6));
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    pic_result_t r;
    int          rem;
    logic [3:0]  op;
    logic [7:0]  idx;
    bit          emit;
    bit          err;
    bit          fin;
    if (seq_aborted || seq_pos >= seq_len) begin
      bytes_dropped++;
      return;
    end
    bytes_decoded++;
    rem  = seq_len - seq_pos - 1;
    r    = '{ACT_NONE, 8'd0, 8'd0, 8'd1, ST_BUSY};
    emit = 1'b0;
    err  = 1'b0;
    fin  = 1'b0;
    if (pending_op == NO_OP) begin
      if (b > 8'(OP_REPEAT)) begin
        err = 1'b1;
      end else begin
        case (b[3:0])
          OP_BEGIN: begin
            r.action = ACT_BEGIN;
            emit = 1'b1;
          end
          OP_END: begin
            r.action = ACT_END;
            emit = 1'b1;
          end
          OP_CMD, OP_DELAY, OP_BYTES: err = (rem < 1);
          OP_C8D8: err = (rem < 2);
          OP_C8D16: err = (rem < 3);
          OP_I2C_REG, OP_I2C_SEQ: err = (rem < 2) || !i2c_on;
          OP_REPEAT: err = (rem < 4) || !i2c_on;
          default: err = 1'b1;
        endcase
        if (!err && b[3:0] >= OP_CMD) begin
          pending_op  = b[3:0] + 4'd1;
          operand_cnt = 8'd0;
          bytes_left  = 8'd0;
        end
      end
    end else begin
      op  = pending_op - 4'd1;
      idx = operand_cnt;
      if (operand_cnt < 8'd255) operand_cnt++;
      case (op)
        OP_CMD: begin
          r.action = ACT_CMD;
          r.first_byte = b;
          emit = 1'b1;
          fin = 1'b1;
        end
        OP_C8D8: begin
          r.action = (idx == 8'd0) ? ACT_CMD : ACT_DATA;
          r.first_byte = b;
          emit = 1'b1;
          fin = (idx != 8'd0);
        end
        OP_C8D16: begin
          r.action = (idx == 8'd0) ? ACT_CMD : ACT_DATA;
          r.first_byte = b;
          emit = 1'b1;
          fin = (idx >= 8'd2);
        end
        OP_BYTES: begin
          if (idx == 8'd0) begin
            if (int'(b) > rem) err = 1'b1;
            else if (b == 8'd0) fin = 1'b1;
            else bytes_left = b;
          end else begin
            r.action = ACT_DATA;
            r.first_byte = b;
            emit = 1'b1;
            bytes_left--;
            fin = (bytes_left == 8'd0);
          end
        end
        OP_DELAY: begin
          r.action = ACT_DELAY;
          r.first_byte = b;
          emit = 1'b1;
          fin = 1'b1;
        end
        OP_I2C_REG: begin
          if (idx == 8'd0) begin
            reg_hold = b;
          end else begin
            r.action = ACT_I2C_REG;
            r.first_byte = reg_hold;
            r.second_byte = b;
            emit = 1'b1;
            fin = 1'b1;
          end
        end
        OP_I2C_SEQ: begin
          if (idx == 8'd0) begin
            reg_hold = b;
          end else if (idx == 8'd1) begin
            if (int'(b) > rem) begin
              err = 1'b1;
            end else begin
              r.action = ACT_SEQ_HEAD;
              r.first_byte = reg_hold;
              r.second_byte = b;
              emit = 1'b1;
              bytes_left = b;
              fin = (b == 8'd0);
            end
          end else begin
            r.action = ACT_SEQ_DATA;
            r.first_byte = b;
            emit = 1'b1;
            bytes_left--;
            fin = (bytes_left == 8'd0);
          end
        end
        OP_REPEAT: begin
          if (idx == 8'd0) begin
            count_hold = b;
          end else if (idx == 8'd1) begin
            err = (b != 8'(OP_I2C_REG));
          end else if (idx == 8'd2) begin
            reg_hold = b;
          end else begin
            r.action = ACT_REPEAT;
            r.first_byte = reg_hold;
            r.second_byte = b;
            r.repeat_count = count_hold;
            emit = 1'b1;
            fin = 1'b1;
          end
        end
        default: err = 1'b1;
      endcase
      if (fin || err) pending_op = NO_OP;
    end
    seq_pos++;
    if (err) begin
      r = '{ACT_NONE, 8'd0, 8'd0, 8'd1, ST_ERROR};
      seq_aborted = 1'b1;
      pending_op = NO_OP;
      expected_actions.push_back(r);
    end else if (seq_pos >= seq_len) begin
      r.status = (pending_op != NO_OP) ? ST_ERROR : ST_DONE;
      if (pending_op != NO_OP) seq_aborted = 1'b1;
      pending_op = NO_OP;
      expected_actions.push_back(r);
    end else if (emit) begin
      expected_actions.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_gap(in_idle_on);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_op_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    for (int i = 0; i < 2000 && expected_actions.size() != 0; i++) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input int len, input bit i2c);
    logic [SEQ_LEN_BITS-1:0] upper;
    upper = SEQ_LEN_BITS'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SEQ_LEN;
    cfg_data  <= SEQ_LEN_BITS'(len);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seq_len = len;
    @(negedge clk);
    cfg_index <= CFG_I2C_EN;
    cfg_data  <= {upper[SEQ_LEN_BITS-1:1], i2c};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    i2c_on = i2c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic build_random_op(input bit i2c);
    logic [3:0] opc;
    logic [7:0] n;
    opc = 4'($urandom_range(0, i2c ? 9 : 6));
    stream_bytes.push_back(8'(opc));
    case (opc)
      OP_CMD, OP_DELAY: stream_bytes.push_back(rand_byte());
      OP_C8D8, OP_I2C_REG: repeat (2) stream_bytes.push_back(rand_byte());
      OP_C8D16: repeat (3) stream_bytes.push_back(rand_byte());
      OP_BYTES: begin
        n = rand_count();
        stream_bytes.push_back(n);
        repeat (n) stream_bytes.push_back(rand_byte());
      end
      OP_I2C_SEQ: begin
        n = rand_count();
        stream_bytes.push_back(rand_byte());
        stream_bytes.push_back(n);
        repeat (n) stream_bytes.push_back(rand_byte());
      end
      OP_REPEAT: begin
        stream_bytes.push_back(rand_byte());
        stream_bytes.push_back(8'(OP_I2C_REG));
        repeat (2) stream_bytes.push_back(rand_byte());
      end
      default: ;
    endcase
  endtask

  // Extend the sequence by exactly the queued bytes and play them.
  task automatic run_group(input bit i2c);
    drain();
    set_config(seq_pos + stream_bytes.size(), i2c);
    groups_run++;
    while (stream_bytes.size() != 0) begin
      if ($urandom_range(0, 49) == 0) drain();
      send_byte(stream_bytes.pop_front());
    end
    drain();
  endtask

  task automatic test_reset_defaults();
    send_byte(8'(OP_BEGIN));
    send_byte(rand_byte());
    drain();
  endtask

  task automatic test_every_opcode();
    stream_bytes = {8'(OP_END), 8'(OP_CMD), 8'hff, 8'(OP_C8D8), 8'h00, 8'hff,
                    8'(OP_C8D16), 8'h5a, 8'ha5, 8'hff, 8'(OP_BYTES), 8'h00,
                    8'(OP_DELAY), 8'h00, 8'(OP_I2C_REG), 8'hff, 8'h00,
                    8'(OP_I2C_SEQ), 8'h80, 8'h00, 8'(OP_REPEAT), 8'h00,
                    8'(OP_I2C_REG), 8'h01, 8'hfe};
    run_group(1'b1);
  endtask

  task automatic test_length_changes();
    repeat (4) build_random_op(1'b1);
    set_config(65535, 1'b1);
    while (stream_bytes.size() != 0) send_byte(stream_bytes.pop_front());
    drain();
    set_config(seq_pos, 1'b1);
    repeat (3) send_byte(rand_byte());
    drain();
    set_config(1, 1'b0);
    repeat (2) send_byte(rand_byte());
    drain();
    // hold a command open across a length change
    set_config(seq_pos + 2, 1'b1);
    send_byte(8'(OP_CMD));
    drain();
    set_config(seq_pos, 1'b1);
    send_byte(rand_byte());
    drain();
    set_config(seq_pos + 1, 1'b1);
    send_byte(rand_byte());
    drain();
  endtask

  task automatic test_backpressure();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    stream_bytes.push_back(8'(OP_BYTES));
    stream_bytes.push_back(8'd40);
    repeat (40) stream_bytes.push_back(rand_byte());
    hold_request = 60;
    run_group(1'b1);
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_random_streams();
    bit i2c;
    while (bytes_decoded < 1880) begin
      i2c         = ($urandom_range(0, 3) != 0);
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 10)) build_random_op(i2c);
      run_group(i2c);
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  task automatic test_abort();
    logic [7:0] nested;
    finale = abort_kind_t'($urandom_range(0, 5));
    case (finale)
      END_UNKNOWN_OP: begin
        stream_bytes.push_back(8'($urandom_range(10, 255)));
        repeat (3) stream_bytes.push_back(rand_byte());
        run_group(1'b1);
      end
      END_SHORT_OPCODE: begin
        stream_bytes.push_back(8'($urandom_range(2, 9)));
        run_group(1'b1);
      end
      END_SHORT_COUNT: begin
        stream_bytes.push_back(8'(OP_BYTES));
        stream_bytes.push_back(8'($urandom_range(1, 255)));
        run_group(1'b1);
      end
      END_I2C_OFF: begin
        stream_bytes.push_back(8'($urandom_range(7, 9)));
        repeat (4) stream_bytes.push_back(rand_byte());
        run_group(1'b0);
      end
      END_NESTED_OP: begin
        nested = 8'($urandom_range(0, 254));
        if (nested >= 8'(OP_I2C_REG)) nested++;
        stream_bytes = {8'(OP_REPEAT), rand_byte(), nested, rand_byte(), rand_byte()};
        run_group(1'b1);
      end
      default: begin
        set_config(seq_pos + 6, 1'b1);
        send_byte(8'(OP_I2C_SEQ));
        send_byte(rand_byte());
        send_byte(8'd3);
        send_byte(rand_byte());
        drain();
        set_config(seq_pos + 1, 1'b1);
        send_byte(rand_byte());
        drain();
      end
    endcase
    // drop everything after the abort
    set_config(65535, 1'b1);
    repeat (4) send_byte(rand_byte());
    drain();
  endtask

  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_gap(out_idle_on);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        @(negedge clk);
        out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_actions
    pic_result_t got;
    pic_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_action, out_first_byte, out_second_byte, out_repeat_count, out_status};
      actions_checked++;
      if (expected_actions.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected transfer act=%0d b1=%h b2=%h cnt=%0d st=%0d", $realtime,
                   got.action, got.first_byte, got.second_byte, got.repeat_count, got.status);
        mismatch_count++;
      end else begin
        want = expected_actions.pop_front();
        if (got.action !== want.action || got.first_byte !== want.first_byte ||
            got.second_byte !== want.second_byte || got.repeat_count !== want.repeat_count ||
            got.status !== want.status) begin
          if (mismatch_count < 10) begin
            $display("%0t: expected act=%0d b1=%h b2=%h cnt=%0d st=%0d", $realtime,
                     want.action, want.first_byte, want.second_byte, want.repeat_count,
                     want.status);
            $display("%0t: actual   act=%0d b1=%h b2=%h cnt=%0d st=%0d", $realtime,
                     got.action, got.first_byte, got.second_byte, got.repeat_count,
                     got.status);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op_byte = 8'd0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_SEQ_LEN;
    cfg_data   = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_every_opcode();
    test_length_changes();
    test_backpressure();
    test_random_streams();
    test_abort();
    drain();
    if (expected_actions.size() != 0) begin
      $display("%0d bus actions never arrived", expected_actions.size());
      mismatch_count += expected_actions.size();
    end
    $display("Decoded %0d bytes in %0d command groups, %0d more dropped; %0d actions checked.",
             bytes_decoded, groups_run, bytes_dropped, actions_checked);
    $display("Sequence closed by %s; %0d mismatches.", finale.name(), mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
